// ===== rtl/tsig_pkg.sv =====
// ----------------------------------------------------------------------------
// tsig_pkg: shared types and constants of the terrain skirt index generator
// Command and edge codes, register indexes, queue entry and back-end state.
// ----------------------------------------------------------------------------
package tsig_pkg;

   localparam int CFG_W       = 7;   // width of the count registers
   localparam int SEG_W       = 6;   // segment number
   localparam int MCOORD_W    = 6;   // mask row / column of a load item
   localparam int INDEX_W     = 32;  // vertex index
   localparam int TOP_W       = 14;  // top-row indices stay below 2**14
   localparam int SCAN_W      = 14;  // segment * skip_factor + k
   localparam int COORD_W     = 8;   // quad coordinate, enough for 256 quads
   localparam int QUEUE_DEPTH = 2;
   localparam int BEAT_W      = 3;

   localparam logic [BEAT_W-1:0] BEAT_FIRST = 3'd0;
   localparam logic [BEAT_W-1:0] BEAT_LAST  = 3'd5;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_GEN  = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      EDGE_NORTH = 2'd0,
      EDGE_EAST  = 2'd1,
      EDGE_SOUTH = 2'd2,
      EDGE_WEST  = 2'd3
   } edge_type;

   typedef enum logic [1:0] {
      REG_LOD_VERTEX_COUNT = 2'd0,
      REG_SKIP_FACTOR      = 2'd1,
      REG_BASE_QUAD_COUNT  = 2'd2,
      REG_MASK_ENABLED     = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_SCAN,
      BK_EMIT
   } back_state_type;

   typedef struct packed {
      logic [CFG_W-1:0] lod_vertex_count;
      logic [CFG_W-1:0] skip_factor;
      logic [CFG_W-1:0] base_quad_count;
      logic             mask_enabled;
   } cfg_type;

   // one classified item between front and back
   typedef struct packed {
      command_type         kind;
      logic [MCOORD_W-1:0] mask_row;
      logic [MCOORD_W-1:0] mask_col;
      logic                mask_value;
      logic                winding_ne;   // north / east winding
      logic [TOP_W-1:0]    top_cur;
      logic [TOP_W-1:0]    top_nxt;
      logic [INDEX_W-1:0]  bot_cur;
      logic [INDEX_W-1:0]  bot_nxt;
      logic                scan_on;
      logic                along_x;
      logic [SCAN_W-1:0]   scan_base;
      logic [COORD_W-1:0]  quad_last;
      logic [COORD_W-1:0]  fixed_coord;
   } entry_type;

   typedef struct packed {
      logic clearing;
      logic emitting;
   } back_status_type;

endpackage

// ===== rtl/tsig_req_if.sv =====
// ----------------------------------------------------------------------------
// tsig_req_if: input item channel
// Valid/ready handshake carrying one load or generate item.
// ----------------------------------------------------------------------------
interface tsig_req_if import tsig_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                command;
   logic [1:0]          edge_req;
   logic [SEG_W-1:0]    segment;
   logic [INDEX_W-1:0]  skirt_start;
   logic [MCOORD_W-1:0] mask_row;
   logic [MCOORD_W-1:0] mask_col;
   logic                mask_value;

   modport source (
      output valid, command, edge_req, segment, skirt_start, mask_row, mask_col,
             mask_value,
      input  ready
   );
   modport sink (
      input  valid, command, edge_req, segment, skirt_start, mask_row, mask_col,
             mask_value,
      output ready
   );
endinterface

// ===== rtl/tsig_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tsig_rsp_if: result item channel
// Valid/ready handshake carrying one vertex index and the segment end flag.
// ----------------------------------------------------------------------------
interface tsig_rsp_if import tsig_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] vertex_index;
   logic               last;

   modport source (output valid, vertex_index, last, input ready);
   modport sink   (input valid, vertex_index, last, output ready);
endinterface

// ===== rtl/tsig_front.sv =====
// ----------------------------------------------------------------------------
// tsig_front: item intake and classification
// Drops items that produce nothing, precomputes indices and scan bounds,
// and holds one classified entry for the queue.
// ----------------------------------------------------------------------------
module tsig_front import tsig_pkg::*; #(
   parameter int MAX_QUADS = 64
) (
   input  logic           clock,
   input  logic           reset,
   tsig_req_if.sink       req_chan,
   input  cfg_type        cfg,
   input  logic           hold,
   output logic           push_valid,
   output entry_type      push_entry,
   input  logic           push_ready
);

   localparam logic [8:0] MAXQ = 9'(MAX_QUADS);

   logic                 stage_valid_ff, stage_valid_in;
   entry_type            stage_ff, stage_in;
   logic                 accept;
   logic                 keep;
   logic [CFG_W-1:0]     n;
   logic [CFG_W-1:0]     nm1;
   logic                 seg_ok;
   logic                 load_ok;
   logic [TOP_W-1:0]     seg_n;
   logic [TOP_W-1:0]     nm1_n;
   logic [8:0]           quad_cnt;
   logic [COORD_W-1:0]   quad_last;
   edge_type             edge_code;

   assign req_chan.ready = !hold && (!stage_valid_ff || push_ready);
   assign accept         = req_chan.valid && req_chan.ready;

   assign n         = cfg.lod_vertex_count;
   assign nm1       = n - 7'd1;
   assign edge_code = edge_type'(req_chan.edge_req);
   assign seg_ok    = (n >= 7'd2) && ({1'b0, req_chan.segment} < nm1);
   assign load_ok   = ({3'b0, req_chan.mask_row} < MAXQ) && ({3'b0, req_chan.mask_col} < MAXQ);
   assign seg_n     = TOP_W'(req_chan.segment) * TOP_W'(n);
   assign nm1_n     = TOP_W'(nm1) * TOP_W'(n);
   assign quad_cnt  = ({2'b0, cfg.base_quad_count} > MAXQ) ? MAXQ : {2'b0, cfg.base_quad_count};
   assign quad_last = COORD_W'(quad_cnt - 9'd1);

   always_comb begin
      stage_in             = stage_ff;
      stage_in.kind        = command_type'(req_chan.command);
      stage_in.mask_row    = req_chan.mask_row;
      stage_in.mask_col    = req_chan.mask_col;
      stage_in.mask_value  = req_chan.mask_value;
      stage_in.winding_ne  = (edge_code == EDGE_NORTH) || (edge_code == EDGE_EAST);
      stage_in.bot_cur     = req_chan.skirt_start + INDEX_W'(req_chan.segment);
      stage_in.bot_nxt     = req_chan.skirt_start + INDEX_W'(req_chan.segment) + 32'd1;
      stage_in.scan_on     = cfg.mask_enabled && (quad_cnt != 9'd0) && (cfg.skip_factor != 7'd0);
      stage_in.along_x     = !req_chan.edge_req[0];
      stage_in.scan_base   = SCAN_W'(req_chan.segment) * SCAN_W'(cfg.skip_factor);
      stage_in.quad_last   = quad_last;
      stage_in.fixed_coord = stage_in.winding_ne ? quad_last : '0;
      unique case (edge_code)
         EDGE_NORTH: begin
            stage_in.top_cur = nm1_n + TOP_W'(req_chan.segment);
            stage_in.top_nxt = stage_in.top_cur + 14'd1;
         end
         EDGE_EAST: begin
            stage_in.top_cur = seg_n + TOP_W'(nm1);
            stage_in.top_nxt = stage_in.top_cur + TOP_W'(n);
         end
         EDGE_SOUTH: begin
            stage_in.top_cur = TOP_W'(req_chan.segment);
            stage_in.top_nxt = stage_in.top_cur + 14'd1;
         end
         default: begin
            stage_in.top_cur = seg_n;
            stage_in.top_nxt = seg_n + TOP_W'(n);
         end
      endcase
   end

   assign keep = (req_chan.command == CMD_GEN) ? seg_ok : load_ok;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (push_valid && push_ready) begin
         stage_valid_in = 1'b0;
      end
      if (accept) begin
         stage_valid_in = keep;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

   assign push_valid = stage_valid_ff;
   assign push_entry = stage_ff;

endmodule

// ===== rtl/tsig_queue.sv =====
// ----------------------------------------------------------------------------
// tsig_queue: short entry queue between front and back
// Circular buffer of classified entries; push and pop in the same cycle.
// ----------------------------------------------------------------------------
module tsig_queue import tsig_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   input  entry_type push_entry,
   output logic      push_ready,
   output logic      pop_valid,
   output entry_type pop_entry,
   input  logic      pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   entry_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/tsig_back.sv =====
// ----------------------------------------------------------------------------
// tsig_back: hole mask store, edge scan and index emission
// Clears the mask after reset, applies loads, scans one mask quad per cycle
// and emits the six indices of a segment.
// ----------------------------------------------------------------------------
module tsig_back import tsig_pkg::*; #(
   parameter int MAX_QUADS = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            q_valid,
   input  entry_type       q_entry,
   output logic            q_pop,
   tsig_rsp_if.source      rsp_chan,
   output back_status_type status
);

   localparam int MEM_DEPTH = MAX_QUADS * MAX_QUADS;
   localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam logic [AW-1:0] MEM_LAST    = AW'(MEM_DEPTH - 1);
   localparam logic [AW-1:0] QUAD_STRIDE = AW'(MAX_QUADS);

   back_state_type      state_ff, state_in;
   logic [AW-1:0]       clr_addr_ff, clr_addr_in;
   logic [CFG_W-1:0]    k_ff, k_in;
   logic                rd_pend_ff, rd_pend_in;
   logic [BEAT_W-1:0]   beat_ff, beat_in;
   entry_type           cur_ff, cur_in;
   logic                hole_mem [MEM_DEPTH];
   logic                rd_data_ff;
   logic                mem_we;
   logic                mem_wdata;
   logic [AW-1:0]       mem_waddr;
   logic [AW-1:0]       mem_raddr;
   logic [AW-1:0]       load_addr;
   logic                scan_issue;
   logic                hole_hit;
   logic [SCAN_W-1:0]   moving_raw;
   logic [COORD_W-1:0]  moving;
   logic [COORD_W-1:0]  qx, qz;
   logic                head_is_gen;

   assign scan_issue  = (k_ff < cfg.skip_factor);
   assign hole_hit    = rd_pend_ff && rd_data_ff;
   assign moving_raw  = cur_ff.scan_base + SCAN_W'(k_ff);
   assign moving      = (moving_raw > SCAN_W'(cur_ff.quad_last)) ?
                        cur_ff.quad_last : moving_raw[COORD_W-1:0];
   assign qx          = cur_ff.along_x ? moving : cur_ff.fixed_coord;
   assign qz          = cur_ff.along_x ? cur_ff.fixed_coord : moving;
   assign mem_raddr   = AW'(qz) * QUAD_STRIDE + AW'(qx);
   assign load_addr   = AW'(q_entry.mask_row) * QUAD_STRIDE + AW'(q_entry.mask_col);
   assign head_is_gen = (q_entry.kind == CMD_GEN);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_CLEAR: begin
            if (clr_addr_ff == MEM_LAST) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (q_valid && head_is_gen) begin
               state_in = q_entry.scan_on ? BK_SCAN : BK_EMIT;
            end
         end
         BK_SCAN: begin
            priority if (hole_hit) begin
               state_in = BK_IDLE;
            end else if (!scan_issue) begin
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (rsp_chan.ready && (beat_ff == BEAT_LAST)) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // outputs and datapath controls
   always_comb begin
      q_pop       = 1'b0;
      mem_we      = 1'b0;
      mem_wdata   = 1'b0;
      mem_waddr   = load_addr;
      clr_addr_in = clr_addr_ff;
      k_in        = k_ff;
      rd_pend_in  = 1'b0;
      beat_in     = beat_ff;
      cur_in      = cur_ff;
      unique case (state_ff)
         BK_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
         end
         BK_IDLE: begin
            q_pop = q_valid;
            if (q_valid) begin
               cur_in  = q_entry;
               k_in    = '0;
               beat_in = BEAT_FIRST;
               if (!head_is_gen) begin
                  mem_we    = 1'b1;
                  mem_wdata = q_entry.mask_value;
               end
            end
         end
         BK_SCAN: begin
            if (scan_issue && !hole_hit) begin
               k_in       = k_ff + 1'b1;
               rd_pend_in = 1'b1;
            end
         end
         BK_EMIT: begin
            if (rsp_chan.ready) begin
               beat_in = beat_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BK_CLEAR;
         clr_addr_ff <= '0;
         k_ff        <= '0;
         rd_pend_ff  <= 1'b0;
         beat_ff     <= BEAT_FIRST;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         k_ff        <= k_in;
         rd_pend_ff  <= rd_pend_in;
         beat_ff     <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hole_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= hole_mem[mem_raddr];
   end

   // winding: north/east tc,tn,bc,bc,tn,bn; south/west tc,bc,tn,tn,bc,bn
   always_comb begin
      unique case (beat_ff)
         3'd0: rsp_chan.vertex_index = INDEX_W'(cur_ff.top_cur);
         3'd1: rsp_chan.vertex_index = cur_ff.winding_ne ? INDEX_W'(cur_ff.top_nxt) : cur_ff.bot_cur;
         3'd2: rsp_chan.vertex_index = cur_ff.winding_ne ? cur_ff.bot_cur : INDEX_W'(cur_ff.top_nxt);
         3'd3: rsp_chan.vertex_index = cur_ff.winding_ne ? cur_ff.bot_cur : INDEX_W'(cur_ff.top_nxt);
         3'd4: rsp_chan.vertex_index = cur_ff.winding_ne ? INDEX_W'(cur_ff.top_nxt) : cur_ff.bot_cur;
         default: rsp_chan.vertex_index = cur_ff.bot_nxt;
      endcase
   end

   assign rsp_chan.valid   = (state_ff == BK_EMIT);
   assign rsp_chan.last    = (beat_ff == BEAT_LAST);
   assign status.clearing  = (state_ff == BK_CLEAR);
   assign status.emitting  = (state_ff == BK_EMIT);

endmodule

// ===== rtl/terrain_skirt_index_gen.sv =====
// ----------------------------------------------------------------------------
// terrain_skirt_index_gen: triangle indices of a terrain tile skirt
// One generate item yields the six indices of one edge segment unless a
// hole lies under it; load items write single hole mask bits.
// ----------------------------------------------------------------------------
// Flow: an accepted generate item is registered in the front stage, waits
//   in the queue and is popped by the back end while it is idle; with mask
//   checks on it then scans the hole mask, and it emits its six indices as
//   the output takes them; no new item is popped before the segment is done.
// Reset: synchronous, active high; registers return to 65, 1, 64, 0, then the
//   hole mask is swept clear with intake held.
// ----------------------------------------------------------------------------
module terrain_skirt_index_gen import tsig_pkg::*; #(
   parameter int MAX_QUADS = 64
) (
   input  logic        clock,
   input  logic        reset,
   tsig_req_if.sink    req_chan,
   tsig_rsp_if.source  rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cfg_type         cfg_ff;
   logic            csr_wr;
   reg_index_type   csr_index;
   logic            push_valid;
   entry_type       push_entry;
   logic            push_ready;
   logic            q_valid;
   entry_type       q_entry;
   logic            q_pop;
   back_status_type status;

   // ---------------------------------------------------------------
   // Configuration: writes land at the access phase, reads are direct
   // ---------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_wr    = psel && penable && pwrite;
   assign csr_index = reg_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lod_vertex_count <= 7'd65;
         cfg_ff.skip_factor      <= 7'd1;
         cfg_ff.base_quad_count  <= 7'd64;
         cfg_ff.mask_enabled     <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_index)
            REG_LOD_VERTEX_COUNT: cfg_ff.lod_vertex_count <= pwdata[CFG_W-1:0];
            REG_SKIP_FACTOR:      cfg_ff.skip_factor      <= pwdata[CFG_W-1:0];
            REG_BASE_QUAD_COUNT:  cfg_ff.base_quad_count  <= pwdata[CFG_W-1:0];
            default:              cfg_ff.mask_enabled     <= pwdata[0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_LOD_VERTEX_COUNT: prdata = 32'(cfg_ff.lod_vertex_count);
         REG_SKIP_FACTOR:      prdata = 32'(cfg_ff.skip_factor);
         REG_BASE_QUAD_COUNT:  prdata = 32'(cfg_ff.base_quad_count);
         default:              prdata = 32'(cfg_ff.mask_enabled);
      endcase
   end

   // ---------------------------------------------------------------
   // Front end: accept, drop items with no effect, precompute indices.
   // Hold intake while the hole mask sweep runs.
   // ---------------------------------------------------------------
   tsig_front #(
      .MAX_QUADS (MAX_QUADS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .cfg        (cfg_ff),
      .hold       (status.clearing),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   // Queue: lets the front keep taking items while the back scans or emits
   tsig_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (q_valid),
      .pop_entry  (q_entry),
      .pop        (q_pop)
   );

   // Back end: mask store, edge scan, six-beat index output
   tsig_back #(
      .MAX_QUADS (MAX_QUADS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_valid  (q_valid),
      .q_entry  (q_entry),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan),
      .status   (status)
   );

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   a_no_result_while_clearing: assert property (
      @(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !status.clearing
   ) else $error("result offered during hole mask sweep");

   a_no_intake_while_clearing: assert property (
      @(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |-> !status.clearing
   ) else $error("item accepted during hole mask sweep");

   a_last_closes_segment: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && rsp_chan.last) |=> !rsp_chan.valid
   ) else $error("output still valid after the last index of a segment");

   a_emit_matches_valid: assert property (
      @(posedge clock) disable iff (reset)
      status.emitting |-> (rsp_chan.valid && !q_pop)
   ) else $error("queue popped while a segment is being emitted");

endmodule
